// ----- src/fesc_pkg.sv -----
// fesc_pkg: shared types for the frame epoch sequence checker
// holds the dispositions and the transfer payload structs; no dependencies
package fesc_pkg;

  // classification of one frame descriptor
  typedef enum logic [3:0] {
    DISP_INVALID   = 4'd0,
    DISP_RETIRED   = 4'd1,
    DISP_NEEDS_IDR = 4'd2,
    DISP_STALE     = 4'd3,
    DISP_CONFLICT  = 4'd4,
    DISP_DUPLICATE = 4'd5,
    DISP_NOT_FRESH = 4'd6,
    DISP_FRESH     = 4'd7,
    DISP_ADVANCED  = 4'd8
  } disp_e;

  // frame flags as stored: bit0 key frame, bit1 repeated, bit2 updated
  typedef logic [2:0] frame_flags_t;

  // one frame descriptor
  typedef struct packed {
    logic        identity_valid;
    logic [31:0] epoch_id;
    logic [31:0] seq_num;
    logic [63:0] fingerprint;
    logic        key_frame;
    logic        repeated;
    logic        picture_updated;
  } frame_desc_t;

  // one classification result
  typedef struct packed {
    disp_e       disposition;
    logic        accepted;
    logic        epoch_opened;
    logic [63:0] transition_count;
  } frame_result_t;

endpackage

// ----- src/fesc_if.sv -----
// fesc_in_if / fesc_out_if: valid-ready channels for descriptors and results
// depends on fesc_pkg for the payload types
interface fesc_in_if import fesc_pkg::*; ();
  logic        valid;
  logic        ready;
  frame_desc_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fesc_out_if import fesc_pkg::*; ();
  logic          valid;
  logic          ready;
  frame_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/frame_epoch_sequence_checker.sv -----
// frame_epoch_sequence_checker: classifies frame descriptors against the
// tracked epoch and last sequence; depends on fesc_pkg and fesc_if.sv
// path: each descriptor passes the input register, then the result register
// throughput: one descriptor per cycle while results are taken, set by the state update
// between the input register and the result register
// reset: all tracking state and the transition counter clear at once
module frame_epoch_sequence_checker import fesc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  fesc_in_if.sink    in_i,
  fesc_out_if.source out_o
);

  // pipeline registers
  logic          in_vld_q;
  frame_desc_t   in_q;
  logic          out_vld_q;
  frame_result_t out_q;
  frame_result_t res_d;
  logic          advance;

  // tracking state
  logic          epoch_known_q, epoch_known_d;
  logic [31:0]   cur_epoch_q, cur_epoch_d;
  logic          seq_known_q, seq_known_d;
  logic [31:0]   last_seq_q, last_seq_d;
  logic [63:0]   last_fp_q, last_fp_d;
  frame_flags_t  last_flags_q, last_flags_d;
  logic [63:0]   trans_q, trans_d;

  // classification helpers
  frame_flags_t  flags;
  logic          fresh;
  logic          epoch_ahead;

  // the result register frees up when empty or when its transfer completes
  assign advance     = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || advance;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
  end

  // classification and next tracking state
  always_comb begin
    flags       = {in_q.picture_updated, in_q.repeated, in_q.key_frame};
    fresh       = in_q.picture_updated && !in_q.repeated;
    epoch_ahead = !epoch_known_q || (in_q.epoch_id > cur_epoch_q);

    epoch_known_d = epoch_known_q;
    cur_epoch_d   = cur_epoch_q;
    seq_known_d   = seq_known_q;
    last_seq_d    = last_seq_q;
    last_fp_d     = last_fp_q;
    last_flags_d  = last_flags_q;
    trans_d       = trans_q;

    res_d.disposition  = DISP_INVALID;
    res_d.accepted     = 1'b0;
    res_d.epoch_opened = 1'b0;

    priority if (!in_q.identity_valid) begin
      res_d.disposition = DISP_INVALID;
    end else if (epoch_known_q && (in_q.epoch_id < cur_epoch_q)) begin
      res_d.disposition = DISP_RETIRED;
    end else if (epoch_ahead && !(fresh && in_q.key_frame)) begin
      res_d.disposition = DISP_NEEDS_IDR;
    end else if (epoch_ahead) begin
      // fresh idr opens the epoch and becomes the last observed frame
      epoch_known_d      = 1'b1;
      cur_epoch_d        = in_q.epoch_id;
      seq_known_d        = 1'b1;
      last_seq_d         = in_q.seq_num;
      last_fp_d          = in_q.fingerprint;
      last_flags_d       = flags;
      trans_d            = (&trans_q) ? trans_q : trans_q + 64'd1;
      res_d.disposition  = DISP_ADVANCED;
      res_d.accepted     = 1'b1;
      res_d.epoch_opened = 1'b1;
    end else if (seq_known_q && (in_q.seq_num < last_seq_q)) begin
      res_d.disposition = DISP_STALE;
    end else if (seq_known_q && (in_q.seq_num == last_seq_q)) begin
      if ((in_q.fingerprint != last_fp_q) || (flags != last_flags_q)) begin
        res_d.disposition = DISP_CONFLICT;
      end else begin
        res_d.disposition = DISP_DUPLICATE;
      end
    end else begin
      // newer sequence within the epoch
      seq_known_d       = 1'b1;
      last_seq_d        = in_q.seq_num;
      last_fp_d         = in_q.fingerprint;
      last_flags_d      = flags;
      res_d.disposition = fresh ? DISP_FRESH : DISP_NOT_FRESH;
      res_d.accepted    = fresh;
    end

    res_d.transition_count = trans_d;
  end

  // tracking state update, once per descriptor moved into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_known_q <= 1'b0;
      cur_epoch_q   <= '0;
      seq_known_q   <= 1'b0;
      last_seq_q    <= '0;
      last_fp_q     <= '0;
      last_flags_q  <= '0;
      trans_q       <= '0;
    end else if (advance) begin
      epoch_known_q <= epoch_known_d;
      cur_epoch_q   <= cur_epoch_d;
      seq_known_q   <= seq_known_d;
      last_seq_q    <= last_seq_d;
      last_fp_q     <= last_fp_d;
      last_flags_q  <= last_flags_d;
      trans_q       <= trans_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  // accepted only for fresh or epoch-advancing frames
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.accepted |->
      (out_q.disposition == DISP_FRESH) || (out_q.disposition == DISP_ADVANCED))
    else $error("accepted result with a rejecting disposition");

  // an epoch change always reports the advanced disposition
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.epoch_opened |-> out_q.disposition == DISP_ADVANCED)
    else $error("epoch change without advanced disposition");

  // the transition counter never moves backward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> trans_q >= $past(trans_q))
    else $error("transition counter decreased");

  // once known, the tracked epoch never moves backward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(epoch_known_q) |-> epoch_known_q && (cur_epoch_q >= $past(cur_epoch_q)))
    else $error("tracked epoch moved backward");

  // a free result register never stalls a waiting descriptor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !out_vld_q |=> out_vld_q)
    else $error("descriptor held while the result register was free");

endmodule

// ----- verif/frame_epoch_sequence_checker_tb.sv -----
// frame_epoch_sequence_checker_tb: directed table then random descriptor streams,
// every result checked against its typed expectation or a behavioral classifier, with random idling on both sides
// depends on fesc_pkg, fesc_if.sv and frame_epoch_sequence_checker.sv
module frame_epoch_sequence_checker_tb;
  import fesc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] FP_A = 64'h0123_4567_89ab_cdef;
  localparam logic [31:0] EPOCH_MAX = 32'hffff_ffff;
  localparam int unsigned RANDOM_FRAMES = 1130;
  localparam int unsigned QUIET_FROM = 1000;

  // one directed row: the descriptor and, where typed in, its expected result
  typedef struct {
    frame_desc_t   desc;
    bit            typed;
    frame_result_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  fesc_in_if  in_if ();
  fesc_out_if out_if ();

  frame_epoch_sequence_checker uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // tracked stream state of the classifier
  bit           trk_epoch_known = 1'b0;
  logic [31:0]  trk_epoch       = '0;
  bit           trk_seq_known   = 1'b0;
  logic [31:0]  trk_last_seq    = '0;
  logic [63:0]  trk_last_fp     = '0;
  frame_flags_t trk_last_flags  = '0;
  logic [63:0]  trk_transitions = '0;

  frame_result_t pending_results[$];
  stim_row_t     stim_table[$];
  int unsigned   mismatch_count = 0;
  int unsigned   src_gap_pct = 0;
  int unsigned   sink_stall_pct = 0;
  bit            quiet = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 5;
      default: return 25;
    endcase
  endfunction

  function automatic frame_desc_t desc(input int v, input logic [31:0] ep,
                                       input logic [31:0] sq, input logic [63:0] fp,
                                       input int k, input int r, input int u);
    frame_desc_t d;
    d.identity_valid  = v[0];
    d.epoch_id        = ep;
    d.seq_num         = sq;
    d.fingerprint     = fp;
    d.key_frame       = k[0];
    d.repeated        = r[0];
    d.picture_updated = u[0];
    return d;
  endfunction

  function automatic frame_result_t outcome(input disp_e disp, input int acc,
                                            input int chg, input int unsigned cnt);
    frame_result_t res;
    res.disposition      = disp;
    res.accepted         = acc[0];
    res.epoch_opened     = chg[0];
    res.transition_count = 64'(cnt);
    return res;
  endfunction

  task automatic add_row(input frame_desc_t d, input int typed, input frame_result_t w);
    stim_row_t row;
    row.desc  = d;
    row.typed = (typed != 0);
    row.want  = w;
    stim_table.push_back(row);
  endtask

  // classify one descriptor and advance the tracked stream state
  function automatic frame_result_t classify_frame(input frame_desc_t d);
    frame_result_t res;
    frame_flags_t  flags;
    disp_e         disp;
    logic          fresh;
    logic          newer;
    logic          changed;
    flags   = {d.picture_updated, d.repeated, d.key_frame};
    fresh   = d.picture_updated && !d.repeated;
    changed = 1'b0;
    if (!d.identity_valid) begin
      disp = DISP_INVALID;
    end else if (trk_epoch_known && d.epoch_id < trk_epoch) begin
      disp = DISP_RETIRED;
    end else begin
      newer = !trk_epoch_known || d.epoch_id > trk_epoch;
      if (newer && !(fresh && d.key_frame)) begin
        disp = DISP_NEEDS_IDR;
      end else begin
        // a fresh idr opens the new epoch and restarts sequence tracking
        if (newer) begin
          trk_epoch_known = 1'b1;
          trk_epoch       = d.epoch_id;
          trk_seq_known   = 1'b0;
          if (trk_transitions != '1) trk_transitions++;
          changed = 1'b1;
        end
        if (trk_seq_known && d.seq_num < trk_last_seq) begin
          disp = DISP_STALE;
        end else if (trk_seq_known && d.seq_num == trk_last_seq) begin
          disp = (d.fingerprint != trk_last_fp || flags != trk_last_flags) ?
                 DISP_CONFLICT : DISP_DUPLICATE;
        end else begin
          // not-fresh frames are still remembered as the last frame
          trk_seq_known  = 1'b1;
          trk_last_seq   = d.seq_num;
          trk_last_fp    = d.fingerprint;
          trk_last_flags = flags;
          disp = !fresh ? DISP_NOT_FRESH : (changed ? DISP_ADVANCED : DISP_FRESH);
        end
      end
    end
    res.disposition      = disp;
    res.accepted         = (disp == DISP_FRESH) || (disp == DISP_ADVANCED);
    res.epoch_opened     = changed;
    res.transition_count = trk_transitions;
    return res;
  endfunction

  // random descriptor, mostly a well-formed continuation of the tracked stream
  function automatic frame_desc_t random_frame();
    frame_desc_t d;
    int unsigned pick;
    d.identity_valid = 1'b1;
    d.epoch_id       = trk_epoch;
    d.seq_num        = trk_last_seq + $urandom_range(1, 4);
    d.fingerprint    = {$urandom, $urandom};
    {d.picture_updated, d.repeated, d.key_frame} = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 3) != 0) begin
      d.repeated        = 1'b0;
      d.picture_updated = 1'b1;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      // invalid identity with noise elsewhere
      d.identity_valid = 1'b0;
      d.epoch_id       = $urandom;
      d.seq_num        = $urandom;
    end else if (pick < 7) begin
      // older epoch
      if (trk_epoch != 0) d.epoch_id = $urandom_range(0, trk_epoch - 1);
    end else if (pick < 13) begin
      // epoch advance, usually by a fresh idr
      d.epoch_id = trk_epoch + (($urandom_range(0, 7) == 0) ?
                   $urandom_range(1, 100000) : $urandom_range(1, 3));
      d.seq_num = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 15);
      if ($urandom_range(0, 4) != 0) begin
        d.key_frame       = 1'b1;
        d.repeated        = 1'b0;
        d.picture_updated = 1'b1;
      end
    end else if (pick < 16) begin
      // newer epoch anywhere in range, never a fresh idr
      d.epoch_id = $urandom_range(trk_epoch + 1, EPOCH_MAX);
      if (d.key_frame && d.picture_updated && !d.repeated) d.key_frame = 1'b0;
    end else if (pick < 24) begin
      // exact repeat of the last frame
      d.seq_num     = trk_last_seq;
      d.fingerprint = trk_last_fp;
      {d.picture_updated, d.repeated, d.key_frame} = trk_last_flags;
    end else if (pick < 29) begin
      // same sequence with one fingerprint bit or one flag changed
      d.seq_num     = trk_last_seq;
      d.fingerprint = trk_last_fp;
      {d.picture_updated, d.repeated, d.key_frame} = trk_last_flags;
      if ($urandom_range(0, 1)) begin
        d.fingerprint = trk_last_fp ^ (64'h1 << $urandom_range(0, 63));
      end else begin
        {d.picture_updated, d.repeated, d.key_frame} =
          trk_last_flags ^ (3'b001 << $urandom_range(0, 2));
      end
    end else if (pick < 34) begin
      // older sequence
      d.seq_num = (trk_last_seq == 0) ? 32'd0 : $urandom_range(0, trk_last_seq - 1);
    end
    return d;
  endfunction

  // drive one descriptor until its transfer, then record what it should produce
  task automatic send_frame(input frame_desc_t d, input bit typed, input frame_result_t w);
    frame_result_t predicted;
    if (!quiet && $urandom_range(0, 99) < src_gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= d;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predicted = classify_frame(d);
    pending_results.push_back(typed ? w : predicted);
  endtask

  // result side backpressure
  initial begin
    int unsigned cycles;
    cycles = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (cycles % 64 == 0) sink_stall_pct = pick_pct();
      if (!quiet && $urandom_range(0, 99) < sink_stall_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      cycles++;
    end
  end

  // compare each result transfer with the oldest pending expectation
  always @(posedge clk_i) begin
    frame_result_t got;
    frame_result_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready) begin
      got = out_if.data;
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (got.disposition !== want.disposition)
          report_mismatch($sformatf("disposition got %0d want %0d",
                                    got.disposition, want.disposition));
        if (got.accepted !== want.accepted)
          report_mismatch($sformatf("accepted got %b want %b", got.accepted, want.accepted));
        if (got.epoch_opened !== want.epoch_opened)
          report_mismatch($sformatf("epoch_opened got %b want %b",
                                    got.epoch_opened, want.epoch_opened));
        if (got.transition_count !== want.transition_count)
          report_mismatch($sformatf("transition_count got %0h want %0h",
                                    got.transition_count, want.transition_count));
      end
    end
  end

  // stimulus
  initial begin
    int unsigned n;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    rst_ni      <= 1'b0;

    // invalid, first valid frame without idr, then the first epoch opens
    add_row(desc(0, EPOCH_MAX, '1, '1, 1, 1, 1), 1, outcome(DISP_INVALID, 0, 0, 0));
    add_row(desc(1, 5, 10, FP_A, 0, 0, 1), 1, outcome(DISP_NEEDS_IDR, 0, 0, 0));
    add_row(desc(1, 5, 10, FP_A, 1, 0, 1), 1, outcome(DISP_ADVANCED, 1, 1, 1));
    // duplicates, conflicts on fingerprint and on flags, stale sequences
    add_row(desc(1, 5, 10, FP_A, 1, 0, 1), 1, outcome(DISP_DUPLICATE, 0, 0, 1));
    add_row(desc(1, 5, 10, FP_A ^ 64'h1, 1, 0, 1), 1, outcome(DISP_CONFLICT, 0, 0, 1));
    add_row(desc(1, 5, 10, FP_A, 0, 0, 1), 1, outcome(DISP_CONFLICT, 0, 0, 1));
    add_row(desc(1, 5, 9, FP_A, 1, 0, 1), 1, outcome(DISP_STALE, 0, 0, 1));
    add_row(desc(1, 5, 0, FP_A, 1, 0, 1), 1, outcome(DISP_STALE, 0, 0, 1));
    // a not-fresh frame is still remembered
    add_row(desc(1, 5, 11, FP_A, 0, 1, 1), 1, outcome(DISP_NOT_FRESH, 0, 0, 1));
    add_row(desc(1, 5, 11, FP_A, 0, 1, 1), 1, outcome(DISP_DUPLICATE, 0, 0, 1));
    add_row(desc(1, 5, 12, '1, 0, 0, 1), 1, outcome(DISP_FRESH, 1, 0, 1));
    add_row(desc(1, 5, 13, '0, 1, 0, 1), 1, outcome(DISP_FRESH, 1, 0, 1));
    // retired epochs, newer epochs without a fresh idr
    add_row(desc(1, 0, 14, FP_A, 1, 0, 1), 1, outcome(DISP_RETIRED, 0, 0, 1));
    add_row(desc(1, 4, 14, FP_A, 1, 0, 1), 1, outcome(DISP_RETIRED, 0, 0, 1));
    add_row(desc(1, EPOCH_MAX, 14, FP_A, 1, 1, 1), 1, outcome(DISP_NEEDS_IDR, 0, 0, 1));
    add_row(desc(1, EPOCH_MAX, 14, FP_A, 1, 0, 0), 1, outcome(DISP_NEEDS_IDR, 0, 0, 1));
    add_row(desc(1, EPOCH_MAX, 14, FP_A, 0, 0, 0), 1, outcome(DISP_NEEDS_IDR, 0, 0, 1));
    // second and third epochs at sequence extremes
    add_row(desc(1, 6, '1, '0, 1, 0, 1), 1, outcome(DISP_ADVANCED, 1, 1, 2));
    add_row(desc(1, 6, '1, '0, 1, 0, 1), 1, outcome(DISP_DUPLICATE, 0, 0, 2));
    add_row(desc(1, 6, 0, '0, 1, 0, 1), 1, outcome(DISP_STALE, 0, 0, 2));
    add_row(desc(1, 7, 0, FP_A, 1, 0, 1), 1, outcome(DISP_ADVANCED, 1, 1, 3));
    add_row(desc(1, 7, 1, FP_A, 0, 1, 0), 1, outcome(DISP_NOT_FRESH, 0, 0, 3));
    add_row(desc(0, $urandom, $urandom, {$urandom, $urandom}, 1, 0, 1), 0, '0);
    add_row(desc(1, 7, 2, {$urandom, $urandom}, $urandom_range(0, 1),
                 $urandom_range(0, 1), $urandom_range(0, 1)), 0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) send_frame(stim_table[i].desc, stim_table[i].typed, stim_table[i].want);

    // random streams; the closing stretch runs without idling
    for (n = 0; n < RANDOM_FRAMES; n++) begin
      if (n % 64 == 0) src_gap_pct = pick_pct();
      if (n == QUIET_FROM) quiet = 1'b1;
      send_frame(random_frame(), 1'b0, '0);
    end
    in_if.valid <= 1'b0;

    // drain, then watch for stray results
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
